### hw/rtl/skv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package skv_pkg;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int VERDICT_W = 2;
    localparam int MAXLEN_W  = 20;
    // byte position / stored lengths never pass the largest allowed packet
    localparam int POS_W     = MAXLEN_W;
    localparam int CNT_W     = 4;
    localparam int WORD_W    = 32;
    // wide sum of running total and one list length
    localparam int SUM_W     = 34;
    localparam int PKT_W     = WORD_W + 1;

    // Message codes
    localparam logic [BYTE_W-1:0] CODE_KEXINIT = 8'd20;
    localparam logic [BYTE_W-1:0] CODE_IGNORE  = 8'd2;

    // Packet layout
    localparam logic [POS_W-1:0] LEN_BYTES    = 20'd4;
    localparam logic [POS_W-1:0] IGNORE_START = 20'd6;
    localparam logic [POS_W-1:0] COOKIE_BYTES = 20'd16;
    localparam logic [POS_W-1:0] TAIL_BYTES   = 20'd5;
    localparam logic [CNT_W-1:0] NAME_LISTS   = 4'd10;

    localparam logic [MAXLEN_W-1:0] MAX_PKT_RESET = 20'd35000;

    typedef enum logic [VERDICT_W-1:0] {
        V_BUSY = 2'd0,
        V_GOOD = 2'd1,
        V_BAD  = 2'd2
    } t_verdict;

    typedef enum logic [8:0] {
        PH_HDR_LEN     = 9'b000000001,
        PH_PAD_LEN     = 9'b000000010,
        PH_CODE        = 9'b000000100,
        PH_SKIP_IGNORE = 9'b000001000,
        PH_PADDING     = 9'b000010000,
        PH_COOKIE      = 9'b000100000,
        PH_LIST_LEN    = 9'b001000000,
        PH_LIST_DATA   = 9'b010000000,
        PH_TAIL        = 9'b100000000
    } t_phase;

endpackage

`default_nettype wire

### hw/rtl/skv_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// Client byte channel
interface skv_byte_if import skv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              flow_start;
    logic              segment_last;

    modport source (output valid, output data_byte, output flow_start,
                    output segment_last, input ready);
    modport sink   (input valid, input data_byte, input flow_start,
                    input segment_last, output ready);
endinterface

// Verdict channel
interface skv_verdict_if import skv_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [VERDICT_W-1:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

// Register write channel
interface skv_cfg_if import skv_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MAXLEN_W-1:0] max_packet_len;

    modport source (output valid, output max_packet_len, input ready);
    modport sink   (input valid, input max_packet_len, output ready);
endinterface

`default_nettype wire

### hw/rtl/ssh2_kexinit_validator.sv
`timescale 1ns / 1ps
`default_nettype none

// SSH-2 key-exchange-init checker for the client byte stream after the banner.
// i_in carries one client byte per word with flow_start (clears the parser
// before the byte) and segment_last (ignored). o_out returns one verdict word
// per input word: 0 in progress, 1 valid key exchange seen, 2 invalid. A
// verdict other than in progress holds until the next flow_start.
// i_cfg writes max_packet_len (always ready); write it only while idle.
// Path: an accepted word passes through the input register and then the
// verdict register. Throughput: one byte per cycle while the receiver does not
// stall, set by the parser state update in the second stage.
// Reset (synchronous, active low) clears the parser to the header phase and
// loads max_packet_len with 35000.
// If the receiver stalls, the verdict register holds and the input register
// still takes one more word; after that i_in.ready drops until the verdict
// is taken.
module ssh2_kexinit_validator import skv_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    skv_byte_if.sink      i_in,
    skv_cfg_if.sink       i_cfg,
    skv_verdict_if.source o_out
);

    // Input stage
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_s1_flow_start;

    // Output stage
    logic     r_out_valid;
    t_verdict r_out_verdict;

    // Parser state
    logic [MAXLEN_W-1:0] r_max;
    t_phase              r_phase;
    logic [POS_W-1:0]    r_pos;
    logic [POS_W-1:0]    r_packet_len;
    logic [BYTE_W-1:0]   r_pad_len;
    logic [WORD_W-1:0]   r_shift;
    logic [POS_W-1:0]    r_list_len;
    logic [POS_W-1:0]    r_consumed;
    logic [CNT_W-1:0]    r_list_count;
    t_verdict            r_held;

    // State after an optional flow_start clear
    t_phase            c_phase;
    logic [POS_W-1:0]  c_pos;
    logic [POS_W-1:0]  c_packet_len;
    logic [BYTE_W-1:0] c_pad_len;
    logic [WORD_W-1:0] c_shift;
    logic [POS_W-1:0]  c_list_len;
    logic [POS_W-1:0]  c_consumed;
    logic [CNT_W-1:0]  c_list_count;
    t_verdict          c_held;

    t_phase            n_phase;
    logic [POS_W-1:0]  n_pos;
    logic [POS_W-1:0]  n_packet_len;
    logic [BYTE_W-1:0] n_pad_len;
    logic [WORD_W-1:0] n_shift;
    logic [POS_W-1:0]  n_list_len;
    logic [POS_W-1:0]  n_consumed;
    logic [CNT_W-1:0]  n_list_count;
    t_verdict          n_held;

    logic [WORD_W-1:0] shift_in;
    logic [POS_W-1:0]  pos_inc;
    logic [PKT_W-1:0]  pkt_wide;
    logic [SUM_W-1:0]  sum_wide;
    logic [CNT_W-1:0]  count_inc;

    logic s1_adv;
    logic s2_fire;

    // Handshakes
    assign s1_adv      = !r_out_valid || o_out.ready;
    assign s2_fire     = r_s1_valid && s1_adv;
    assign i_in.ready  = !r_s1_valid || s1_adv;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid   = r_out_valid;
    assign o_out.verdict = r_out_verdict;

    // Clear on flow_start, then derived values
    always_comb begin
        c_phase      = r_phase;
        c_pos        = r_pos;
        c_packet_len = r_packet_len;
        c_pad_len    = r_pad_len;
        c_shift      = r_shift;
        c_list_len   = r_list_len;
        c_consumed   = r_consumed;
        c_list_count = r_list_count;
        c_held       = r_held;
        if (r_s1_flow_start) begin
            c_phase      = PH_HDR_LEN;
            c_pos        = '0;
            c_packet_len = '0;
            c_pad_len    = '0;
            c_shift      = '0;
            c_list_len   = '0;
            c_consumed   = '0;
            c_list_count = '0;
            c_held       = V_BUSY;
        end
    end

    assign shift_in  = {c_shift[WORD_W-BYTE_W-1:0], r_s1_byte};
    assign pos_inc   = c_pos + POS_W'(1);
    assign pkt_wide  = {1'b0, c_shift} + PKT_W'(LEN_BYTES);
    assign sum_wide  = SUM_W'(c_consumed) + SUM_W'(shift_in) + SUM_W'(LEN_BYTES);
    assign count_inc = c_list_count + CNT_W'(1);

    // Parser step for one byte
    always_comb begin
        n_phase      = c_phase;
        n_pos        = c_pos;
        n_packet_len = c_packet_len;
        n_pad_len    = c_pad_len;
        n_shift      = c_shift;
        n_list_len   = c_list_len;
        n_consumed   = c_consumed;
        n_list_count = c_list_count;
        n_held       = c_held;
        if (c_held == V_BUSY) begin
            unique case (c_phase)
                PH_HDR_LEN: begin
                    n_shift = shift_in;
                    n_pos   = pos_inc;
                    if (pos_inc >= LEN_BYTES) begin
                        n_phase = PH_PAD_LEN;
                    end
                end
                PH_PAD_LEN: begin
                    n_pad_len = r_s1_byte;
                    n_pos     = pos_inc;
                    n_phase   = PH_CODE;
                end
                PH_CODE: begin
                    if (r_s1_byte == CODE_KEXINIT || r_s1_byte == CODE_IGNORE) begin
                        if (r_s1_byte == CODE_KEXINIT) begin
                            n_pos      = '0;
                            n_phase    = PH_COOKIE;
                            n_consumed = POS_W'(c_pad_len) + COOKIE_BYTES + LEN_BYTES;
                        end else begin
                            n_pos   = IGNORE_START;
                            n_phase = PH_SKIP_IGNORE;
                        end
                        // only the low bits matter once the size check passes
                        n_packet_len = pkt_wide[POS_W-1:0];
                        if (pkt_wide > PKT_W'(r_max)) begin
                            n_held = V_BAD;
                        end
                    end else begin
                        n_held = V_BAD;
                    end
                end
                PH_SKIP_IGNORE: begin
                    n_pos = pos_inc;
                    if (pos_inc >= c_packet_len) begin
                        n_phase = PH_HDR_LEN;
                        n_pos   = '0;
                    end
                end
                PH_COOKIE: begin
                    n_pos = pos_inc;
                    if (pos_inc >= COOKIE_BYTES) begin
                        n_phase = PH_LIST_LEN;
                        n_pos   = '0;
                    end
                end
                PH_LIST_LEN: begin
                    n_shift = shift_in;
                    n_pos   = pos_inc;
                    if (pos_inc >= LEN_BYTES) begin
                        n_pos = '0;
                        if (sum_wide > SUM_W'(c_packet_len)) begin
                            n_held = V_BAD;
                        end else begin
                            n_list_len = shift_in[POS_W-1:0];
                            n_consumed = sum_wide[POS_W-1:0];
                            if (shift_in != '0) begin
                                n_phase = PH_LIST_DATA;
                            end else begin
                                n_list_count = count_inc;
                                n_phase = (count_inc >= NAME_LISTS) ? PH_TAIL : PH_LIST_LEN;
                            end
                        end
                    end
                end
                PH_LIST_DATA: begin
                    n_pos = pos_inc;
                    if (pos_inc >= c_list_len) begin
                        n_list_count = count_inc;
                        n_phase = (count_inc >= NAME_LISTS) ? PH_TAIL : PH_LIST_LEN;
                        n_pos   = '0;
                    end
                end
                PH_TAIL: begin
                    // first byte is first-kex-follows, then the reserved word
                    if (c_pos != '0) begin
                        n_shift = shift_in;
                    end
                    n_pos = pos_inc;
                    if (pos_inc >= TAIL_BYTES) begin
                        if (n_shift != '0) begin
                            n_held = V_BAD;
                        end else begin
                            n_phase = PH_PADDING;
                            n_pos   = '0;
                        end
                    end
                end
                PH_PADDING: begin
                    n_pos = pos_inc;
                    if (pos_inc >= POS_W'(c_pad_len)) begin
                        n_held = V_GOOD;
                    end
                end
                default: begin
                    n_held = V_BAD;
                end
            endcase
        end
    end

    // Control and parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_max        <= MAX_PKT_RESET;
            r_phase      <= PH_HDR_LEN;
            r_pos        <= '0;
            r_packet_len <= '0;
            r_pad_len    <= '0;
            r_shift      <= '0;
            r_list_len   <= '0;
            r_consumed   <= '0;
            r_list_count <= '0;
            r_held       <= V_BUSY;
        end else begin
            if (i_cfg.valid) begin
                r_max <= i_cfg.max_packet_len;
            end
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s2_fire) begin
                r_out_valid  <= 1'b1;
                r_phase      <= n_phase;
                r_pos        <= n_pos;
                r_packet_len <= n_packet_len;
                r_pad_len    <= n_pad_len;
                r_shift      <= n_shift;
                r_list_len   <= n_list_len;
                r_consumed   <= n_consumed;
                r_list_count <= n_list_count;
                r_held       <= n_held;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_byte       <= i_in.data_byte;
            r_s1_flow_start <= i_in.flow_start;
        end
        if (s2_fire) begin
            r_out_verdict <= n_held;
        end
    end

    // A verdict word always reports the parser's held verdict
    a_out_matches_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_fire |=> r_out_verdict == r_held)
        else $error("verdict word differs from held verdict");

    // A final verdict sticks unless the byte clears the flow
    a_verdict_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_fire && !r_s1_flow_start && r_held != V_BUSY |-> n_held == r_held)
        else $error("final verdict changed without flow_start");

    // Inside a name list the position stays below its length
    a_list_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_LIST_DATA |-> r_pos < r_list_len)
        else $error("list data position past list length");

    // No more than NAME_LISTS name lists are walked
    a_list_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_LIST_LEN || r_phase == PH_LIST_DATA |-> r_list_count < NAME_LISTS)
        else $error("name list count overrun");

endmodule

`default_nettype wire
